FILE: design/wsfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_pkg: shared types and constants for the WebSocket frame receiver
// Parser phase codes, event kinds, opcodes and the result beat layout.
// ----------------------------------------------------------------------------
package wsfr_pkg;

    localparam int RX_W     = 8;
    localparam int KIND_W   = 3;
    localparam int OPCODE_W = 4;
    localparam int MAX_W    = 32;
    localparam int PHASE_W  = 3;
    localparam int MSG_CNT_W = 33;
    localparam int FLEN_W   = 64;
    localparam int USER_W   = KIND_W + OPCODE_W;

    localparam logic [MAX_W-1:0] MAX_MESSAGE_RESET = 32'(1024 * 1024 * 32);

    // parser phases
    localparam logic [PHASE_W-1:0] PH_HEAD1   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_HEAD2   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EXTLEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_MASK    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd4;

    // event kinds
    localparam logic [KIND_W-1:0] EV_PAYLOAD  = 3'd0;
    localparam logic [KIND_W-1:0] EV_MSG_END  = 3'd1;
    localparam logic [KIND_W-1:0] EV_PING     = 3'd2;
    localparam logic [KIND_W-1:0] EV_ERR_RSV  = 3'd3;
    localparam logic [KIND_W-1:0] EV_ERR_SIZE = 3'd4;
    localparam logic [KIND_W-1:0] EV_ERR_OP   = 3'd5;

    // frame opcodes
    localparam logic [OPCODE_W-1:0] OP_CONT   = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_BINARY = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_CLOSE  = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_PING   = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_PONG   = 4'd10;

    // 7-bit length escape codes
    localparam logic [6:0] LEN16_CODE = 7'd126;
    localparam logic [6:0] LEN64_CODE = 7'd127;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [RX_W-1:0]     payload;
        logic [OPCODE_W-1:0] opcode;
        logic                last;
    } wsfr_result_t;

endpackage

FILE: design/wsfr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_parser: frame header parser and payload unmasker
// Holds the frame and message state, consumes one byte per step and gives
// at most one result for that byte.
// ----------------------------------------------------------------------------
module wsfr_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic [wsfr_pkg::RX_W-1:0]     rx_byte,
    input  logic [wsfr_pkg::MAX_W-1:0]    max_message_bytes,
    output logic                          res_valid,
    output wsfr_pkg::wsfr_result_t        res
);

    logic [wsfr_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic [7:0]                     first_header_reg, first_header_next;
    logic                           masked_reg, masked_next;
    logic [3:0]                     len_left_reg, len_left_next;
    logic [wsfr_pkg::FLEN_W-1:0]    frame_len_reg, frame_len_next;
    logic [31:0]                    mask_key_reg, mask_key_next;
    logic [2:0]                     mask_left_reg, mask_left_next;
    logic [1:0]                     mask_pos_reg, mask_pos_next;
    logic [3:0]                     hdr_cnt_reg, hdr_cnt_next;
    logic [wsfr_pkg::OPCODE_W-1:0]  msg_kind_reg, msg_kind_next;
    logic [wsfr_pkg::MSG_CNT_W-1:0] msg_cnt_reg, msg_cnt_next;
    logic [wsfr_pkg::FLEN_W-1:0]    pay_left_reg, pay_left_next;

    logic [wsfr_pkg::OPCODE_W-1:0]  hdr_op;
    logic                           hdr_fin;
    logic                           hdr_ctrl;
    logic [wsfr_pkg::OPCODE_W-1:0]  in_op;
    logic                           in_op_ok;
    logic                           hd_fire;
    logic                           over;
    logic [34:0]                    size_sum;
    logic [wsfr_pkg::OPCODE_W-1:0]  kind_after;
    logic [3:0]                     len_dec;
    logic [2:0]                     mask_dec;
    logic [7:0]                     key_byte;
    logic                           pay_done;

    assign hdr_op   = first_header_reg[3:0];
    assign hdr_fin  = first_header_reg[7];
    assign hdr_ctrl = (hdr_op == wsfr_pkg::OP_PING) || (hdr_op == wsfr_pkg::OP_PONG);
    assign in_op    = rx_byte[3:0];
    assign in_op_ok = (in_op <= wsfr_pkg::OP_BINARY) ||
                      ((in_op >= wsfr_pkg::OP_CLOSE) && (in_op <= wsfr_pkg::OP_PONG));
    assign len_dec  = len_left_reg - {3'b0, (len_left_reg != 4'd0)};
    assign mask_dec = mask_left_reg - {2'b0, (mask_left_reg != 3'd0)};
    assign pay_done = (pay_left_reg[wsfr_pkg::FLEN_W-1:1] == '0);

    always_comb begin
        case (mask_pos_reg)
            2'd0:    key_byte = mask_key_reg[31:24];
            2'd1:    key_byte = mask_key_reg[23:16];
            2'd2:    key_byte = mask_key_reg[15:8];
            default: key_byte = mask_key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next        = phase_reg;
        first_header_next = first_header_reg;
        masked_next       = masked_reg;
        len_left_next     = len_left_reg;
        frame_len_next    = frame_len_reg;
        mask_key_next     = mask_key_reg;
        mask_left_next    = mask_left_reg;
        mask_pos_next     = mask_pos_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        msg_kind_next     = msg_kind_reg;
        msg_cnt_next      = msg_cnt_reg;
        pay_left_next     = pay_left_reg;
        hd_fire           = 1'b0;
        res_valid         = 1'b0;
        res.kind          = wsfr_pkg::EV_PAYLOAD;
        res.payload       = '0;
        res.opcode        = msg_kind_reg;
        res.last          = 1'b0;
        size_sum          = '0;
        over              = 1'b0;
        kind_after        = msg_kind_reg;

        case (phase_reg)
            wsfr_pkg::PH_HEAD1: begin
                first_header_next = rx_byte;
                if (rx_byte[6:4] != 3'b000) begin
                    res_valid    = 1'b1;
                    res.kind     = wsfr_pkg::EV_ERR_RSV;
                    msg_cnt_next = '0;
                end else if (!in_op_ok) begin
                    res_valid    = 1'b1;
                    res.kind     = wsfr_pkg::EV_ERR_OP;
                    msg_cnt_next = '0;
                end else begin
                    phase_next = wsfr_pkg::PH_HEAD2;
                    if (in_op == wsfr_pkg::OP_PING) begin
                        res_valid = 1'b1;
                        res.kind  = wsfr_pkg::EV_PING;
                    end
                end
            end
            wsfr_pkg::PH_HEAD2: begin
                masked_next    = rx_byte[7];
                hdr_cnt_next   = 4'd2;
                frame_len_next = '0;
                mask_key_next  = '0;
                if (rx_byte[6:0] == wsfr_pkg::LEN16_CODE) begin
                    len_left_next = 4'd2;
                    phase_next    = wsfr_pkg::PH_EXTLEN;
                end else if (rx_byte[6:0] == wsfr_pkg::LEN64_CODE) begin
                    len_left_next = 4'd8;
                    phase_next    = wsfr_pkg::PH_EXTLEN;
                end else begin
                    frame_len_next = {57'b0, rx_byte[6:0]};
                    if (rx_byte[7]) begin
                        mask_left_next = 3'd4;
                        phase_next     = wsfr_pkg::PH_MASK;
                    end else begin
                        hd_fire = 1'b1;
                    end
                end
            end
            wsfr_pkg::PH_EXTLEN: begin
                frame_len_next = {frame_len_reg[wsfr_pkg::FLEN_W-9:0], rx_byte};
                hdr_cnt_next   = hdr_cnt_reg + 4'd1;
                len_left_next  = len_dec;
                if (len_dec == 4'd0) begin
                    if (masked_reg) begin
                        mask_left_next = 3'd4;
                        phase_next     = wsfr_pkg::PH_MASK;
                    end else begin
                        hd_fire = 1'b1;
                    end
                end
            end
            wsfr_pkg::PH_MASK: begin
                mask_key_next  = {mask_key_reg[23:0], rx_byte};
                hdr_cnt_next   = hdr_cnt_reg + 4'd1;
                mask_left_next = mask_dec;
                if (mask_dec == 3'd0) begin
                    hd_fire = 1'b1;
                end
            end
            wsfr_pkg::PH_PAYLOAD: begin
                mask_pos_next = mask_pos_reg + 2'd1;
                pay_left_next = pay_left_reg - {63'b0, (pay_left_reg != '0)};
                if (pay_done) begin
                    phase_next = wsfr_pkg::PH_HEAD1;
                end
                if (!hdr_ctrl) begin
                    msg_cnt_next = msg_cnt_reg + 33'd1;
                    res_valid    = 1'b1;
                    res.payload  = masked_reg ? (rx_byte ^ key_byte) : rx_byte;
                    res.last     = pay_done && hdr_fin;
                    if (pay_done && hdr_fin) begin
                        msg_cnt_next  = '0;
                        msg_kind_next = '0;
                    end
                end
            end
            default: begin
                phase_next = wsfr_pkg::PH_HEAD1;
            end
        endcase

        // header complete: size check, then enter payload or finish the frame
        if (hd_fire) begin
            size_sum = {31'b0, hdr_cnt_next} + {3'b0, frame_len_next[31:0]} +
                       {2'b0, msg_cnt_reg};
            over = (frame_len_next[wsfr_pkg::FLEN_W-1:32] != '0) ||
                   (size_sum > {3'b0, max_message_bytes});
            if (!hdr_ctrl && over) begin
                res_valid    = 1'b1;
                res.kind     = wsfr_pkg::EV_ERR_SIZE;
                msg_cnt_next = '0;
                phase_next   = wsfr_pkg::PH_HEAD1;
            end else begin
                if (!hdr_ctrl && (hdr_op != wsfr_pkg::OP_CONT)) begin
                    kind_after = hdr_op;
                end
                msg_kind_next = kind_after;
                mask_pos_next = '0;
                pay_left_next = frame_len_next;
                if (frame_len_next == '0) begin
                    phase_next = wsfr_pkg::PH_HEAD1;
                    if (!hdr_ctrl && hdr_fin) begin
                        res_valid     = 1'b1;
                        res.kind      = wsfr_pkg::EV_MSG_END;
                        res.opcode    = kind_after;
                        res.last      = 1'b1;
                        msg_cnt_next  = '0;
                        msg_kind_next = '0;
                    end
                end else begin
                    phase_next = wsfr_pkg::PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= wsfr_pkg::PH_HEAD1;
            first_header_reg <= '0;
            masked_reg       <= 1'b0;
            len_left_reg     <= '0;
            frame_len_reg    <= '0;
            mask_key_reg     <= '0;
            mask_left_reg    <= '0;
            mask_pos_reg     <= '0;
            hdr_cnt_reg      <= '0;
            msg_kind_reg     <= '0;
            msg_cnt_reg      <= '0;
            pay_left_reg     <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            first_header_reg <= first_header_next;
            masked_reg       <= masked_next;
            len_left_reg     <= len_left_next;
            frame_len_reg    <= frame_len_next;
            mask_key_reg     <= mask_key_next;
            mask_left_reg    <= mask_left_next;
            mask_pos_reg     <= mask_pos_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            msg_kind_reg     <= msg_kind_next;
            msg_cnt_reg      <= msg_cnt_next;
            pay_left_reg     <= pay_left_next;
        end
    end

    // payload phase always has bytes left to consume
    a_payload_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wsfr_pkg::PH_PAYLOAD) |-> (pay_left_reg != '0))
        else $error("payload phase with no bytes left");

    // every error sends the parser back to header wait
    a_error_recover: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_valid && (res.kind == wsfr_pkg::EV_ERR_RSV ||
         res.kind == wsfr_pkg::EV_ERR_SIZE || res.kind == wsfr_pkg::EV_ERR_OP))
        |=> (phase_reg == wsfr_pkg::PH_HEAD1) && (msg_cnt_reg == '0))
        else $error("error did not reset parser");

    // a finished message clears the message state
    a_msg_end_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res_valid && res.last)
        |=> (msg_cnt_reg == '0) && (msg_kind_reg == '0))
        else $error("message state kept after end");

    // last only marks a payload byte or an empty message end
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.last) |->
        (res.kind == wsfr_pkg::EV_PAYLOAD || res.kind == wsfr_pkg::EV_MSG_END))
        else $error("last on non-data event");

endmodule

FILE: design/wsfr_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfr_out_reg: result register for the event stream
// Holds one result beat until the sink takes it; reloads in the same cycle.
// ----------------------------------------------------------------------------
module wsfr_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  wsfr_pkg::wsfr_result_t         load_res,
    output logic                           can_load,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic [wsfr_pkg::USER_W-1:0]    m_tuser,
    output logic                           m_tlast
);

    logic                   valid_reg;
    wsfr_pkg::wsfr_result_t res_reg;

    assign can_load = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (can_load && load) begin
            res_reg <= load_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.payload;
    assign m_tuser  = {res_reg.opcode, res_reg.kind};
    assign m_tlast  = res_reg.last;

endmodule

FILE: design/websocket_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_receiver: RFC 6455 frame deframer
// Parses received bytes into frames, unmasks payload and reports events.
// ----------------------------------------------------------------------------
//
//  Port group   Dir  Bits  Contents
//  s_*          in   8     received bytes, one per beat
//  m_*          out  8+7+1 payload byte / event kind, opcode / end of message
//  cfg_*        in   32    max_message_bytes write
//
//  One byte per cycle sustained unless a held result stalls the input. Each
//  byte passes the input register, then the parser state update and the
//  result register. The parser updates all frame state in a single step per
//  byte, so the rate is set by that state loop.
//  Reset (aresetn low, synchronous) clears parser state, valid flags and sets
//  max_message_bytes to 32 MiB.
//  When m_tready is low with a result held, bytes that give no result still
//  advance; a byte that gives a result waits in the input register.
//
// ----------------------------------------------------------------------------
module websocket_frame_receiver (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_wr_en,
    input  logic [wsfr_pkg::MAX_W-1:0]     cfg_wr_data,   // max_message_bytes
    // received bytes
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,       // [7:0] rx_byte
    // events
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,       // [7:0] payload_byte
    output logic [wsfr_pkg::USER_W-1:0]    m_tuser,       // [2:0] event_kind,
                                                          // [6:3] message_opcode
    output logic                           m_tlast        // last
);

    logic [wsfr_pkg::MAX_W-1:0] max_bytes_reg;
    logic                       in_valid_reg;
    logic [7:0]                 in_byte_reg;

    logic                       step;
    logic                       res_valid;
    wsfr_pkg::wsfr_result_t     res;
    logic                       can_load;

    // hold the configured size limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= wsfr_pkg::MAX_MESSAGE_RESET;
        end else if (cfg_wr_en) begin
            max_bytes_reg <= cfg_wr_data;
        end
    end

    // advance the held byte unless its result has nowhere to go
    assign step     = in_valid_reg && (!res_valid || can_load);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    wsfr_parser u_parser (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (step),
        .rx_byte           (in_byte_reg),
        .max_message_bytes (max_bytes_reg),
        .res_valid         (res_valid),
        .res               (res)
    );

    wsfr_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .load_res (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: test/websocket_frame_receiver_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_receiver_checker: event prediction and comparison
// Follows every accepted byte and register write with its own frame parser,
// keeps the events that parser produces and checks each event beat against them.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_checker
    import wsfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [MAX_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [7:0]        m_tdata,
    input  logic [USER_W-1:0] m_tuser,
    input  logic              m_tlast,
    output int                mismatch_count,
    output int                events_pending
);

    // parser copy
    logic [MAX_W-1:0]     max_bytes;
    logic [PHASE_W-1:0]   phase;
    logic [7:0]           head_byte;
    logic                 masked;
    logic [3:0]           len_left;
    logic [FLEN_W-1:0]    frame_len;
    logic [31:0]          mask_key;
    logic [2:0]           key_left;
    logic [1:0]           key_pos;
    logic [3:0]           head_count;
    logic [OPCODE_W-1:0]  msg_opcode;
    logic [MSG_CNT_W-1:0] msg_count;
    logic [FLEN_W-1:0]    body_left;

    wsfr_result_t events_due[$];
    int           bad;

    function automatic wsfr_result_t make_event(input logic [KIND_W-1:0] kind,
                                                input logic [7:0] data,
                                                input logic end_of_msg);
        wsfr_result_t ev;
        ev.kind    = kind;
        ev.payload = data;
        ev.opcode  = msg_opcode;
        ev.last    = end_of_msg;
        return ev;
    endfunction

    function automatic bit is_control(input logic [OPCODE_W-1:0] op);
        return op == OP_PING || op == OP_PONG;
    endfunction

    // Header complete: size check, then payload or immediate end.
    function automatic bit close_header(output wsfr_result_t ev);
        logic [OPCODE_W-1:0] op;
        logic                fin;
        logic [65:0]         total;
        op    = head_byte[3:0];
        fin   = head_byte[7];
        total = 66'(head_count) + 66'(frame_len) + 66'(msg_count);
        if (!is_control(op)) begin
            if (frame_len > 64'hFFFF_FFFF || total > 66'(max_bytes)) begin
                ev        = make_event(EV_ERR_SIZE, 8'h00, 1'b0);
                msg_count = '0;
                phase     = PH_HEAD1;
                return 1'b1;
            end
            if (op != OP_CONT)
                msg_opcode = op;
        end
        key_pos   = '0;
        body_left = frame_len;
        if (frame_len == '0) begin
            phase = PH_HEAD1;
            if (!is_control(op) && fin) begin
                ev         = make_event(EV_MSG_END, 8'h00, 1'b1);
                msg_count  = '0;
                msg_opcode = OP_CONT;
                return 1'b1;
            end
            return 1'b0;
        end
        phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // Advance the parser by one byte; returns 1 when an event comes out.
    function automatic bit parse_byte(input logic [7:0] b, output wsfr_result_t ev);
        logic [OPCODE_W-1:0] op;
        logic [7:0]          data;
        logic                done;
        logic                fin;
        case (phase)
            PH_HEAD1: begin
                op        = b[3:0];
                head_byte = b;
                if (b[6:4] != 3'b000) begin
                    ev        = make_event(EV_ERR_RSV, 8'h00, 1'b0);
                    msg_count = '0;
                    return 1'b1;
                end
                if (!(op <= OP_BINARY || (op >= OP_CLOSE && op <= OP_PONG))) begin
                    ev        = make_event(EV_ERR_OP, 8'h00, 1'b0);
                    msg_count = '0;
                    return 1'b1;
                end
                phase = PH_HEAD2;
                if (op == OP_PING) begin
                    ev = make_event(EV_PING, 8'h00, 1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_HEAD2: begin
                masked     = b[7];
                head_count = 4'd2;
                frame_len  = '0;
                mask_key   = '0;
                if (b[6:0] == LEN16_CODE || b[6:0] == LEN64_CODE) begin
                    len_left = (b[6:0] == LEN16_CODE) ? 4'd2 : 4'd8;
                    phase    = PH_EXTLEN;
                    return 1'b0;
                end
                frame_len = 64'(b[6:0]);
                if (masked) begin
                    key_left = 3'd4;
                    phase    = PH_MASK;
                    return 1'b0;
                end
                return close_header(ev);
            end
            PH_EXTLEN: begin
                frame_len  = {frame_len[FLEN_W-9:0], b};
                head_count = head_count + 4'd1;
                if (len_left != '0)
                    len_left = len_left - 4'd1;
                if (len_left != '0)
                    return 1'b0;
                if (masked) begin
                    key_left = 3'd4;
                    phase    = PH_MASK;
                    return 1'b0;
                end
                return close_header(ev);
            end
            PH_MASK: begin
                mask_key   = {mask_key[23:0], b};
                head_count = head_count + 4'd1;
                if (key_left != '0)
                    key_left = key_left - 3'd1;
                if (key_left != '0)
                    return 1'b0;
                return close_header(ev);
            end
            PH_PAYLOAD: begin
                op   = head_byte[3:0];
                fin  = head_byte[7];
                data = b;
                if (masked)
                    data = data ^ mask_key[8 * (3 - int'(key_pos)) +: 8];
                key_pos = key_pos + 2'd1;
                if (body_left != '0)
                    body_left = body_left - 64'd1;
                done = (body_left == '0);
                if (done)
                    phase = PH_HEAD1;
                if (is_control(op))
                    return 1'b0;
                msg_count = msg_count + 33'd1;
                ev        = make_event(EV_PAYLOAD, data, done && fin);
                if (done && fin) begin
                    msg_count  = '0;
                    msg_opcode = OP_CONT;
                end
                return 1'b1;
            end
            default: begin
                phase = PH_HEAD1;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            bad++;
        end
    endfunction

    initial begin
        bad = 0;
    end

    always @(posedge aclk) begin
        wsfr_result_t ev;
        if (!aresetn) begin
            max_bytes  = MAX_MESSAGE_RESET;
            phase      = PH_HEAD1;
            head_byte  = '0;
            masked     = 1'b0;
            len_left   = '0;
            frame_len  = '0;
            mask_key   = '0;
            key_left   = '0;
            key_pos    = '0;
            head_count = '0;
            msg_opcode = OP_CONT;
            msg_count  = '0;
            body_left  = '0;
            events_due.delete();
        end else begin
            if (cfg_wr_en)
                max_bytes = cfg_wr_data;
            // compare before predicting: no byte reaches the output in its own cycle
            if (m_tvalid && m_tready) begin
                if (events_due.size() == 0) begin
                    $display({"%t: event beat with nothing expected, expected none, ",
                              "actual kind %0h byte %0h opcode %0h last %0b"},
                             $time, m_tuser[KIND_W-1:0], m_tdata,
                             m_tuser[USER_W-1:KIND_W], m_tlast);
                    bad++;
                end else begin
                    ev = events_due.pop_front();
                    check_field("event_kind", ev.kind, m_tuser[KIND_W-1:0]);
                    check_field("payload_byte", ev.payload, m_tdata);
                    check_field("message_opcode", ev.opcode, m_tuser[USER_W-1:KIND_W]);
                    check_field("last", ev.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) begin
                if (parse_byte(s_tdata, ev))
                    events_due.push_back(ev);
            end
        end
        mismatch_count <= bad;
        events_pending <= events_due.size();
    end

endmodule

FILE: test/websocket_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_receiver_tb: frame receiver stimulus and verdict
// Sends directed and random WebSocket frames through the byte stream under
// several size limits, with random gaps and back-pressure; the checker beside
// the block predicts every event beat and counts mismatches.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_tb;
    import wsfr_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int IDLE_PERCENT  = 36;
    localparam int SETTLE_CYCLES = 8;      // covers the input and result registers with margin
    localparam int STALL_LIMIT   = 2000;   // cycles with no beat on either side
    localparam int RANDOM_BYTES  = 170;    // per random phase, three phases

    localparam logic [OPCODE_W-1:0] OP_TEXT = 4'd1;

    typedef enum logic [1:0] {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [MAX_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata     = '0;     // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [7:0]           m_tdata;              // [7:0] payload_byte
    logic [USER_W-1:0]    m_tuser;              // [2:0] event_kind, [6:3] message_opcode
    logic                 m_tlast;

    logic                 calm        = 1'b0;   // high: no gaps, no back-pressure
    logic [7:0]           wire_bytes[$];        // bytes waiting to go out
    int                   mismatch_count;
    int                   events_pending;
    int                   stuck_cycles = 0;
    logic [MAX_W-1:0]     mid_limit;

    always #HALF_PERIOD aclk = ~aclk;

    websocket_frame_receiver dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    websocket_frame_receiver_checker frame_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .events_pending(events_pending)
    );

    // Back-pressure on the event side; released during the calm stretch.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: end the run when neither side moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Queue one frame: header bytes, extended length, mask key, then body_len
    // random body bytes (body_len may differ from flen on purpose).
    task automatic add_frame(input logic fin, input logic [2:0] rsv,
                             input logic [OPCODE_W-1:0] op, input logic masked,
                             input len_form_t form, input logic [63:0] flen,
                             input int body_len);
        logic [31:0] key;
        key = $urandom;
        wire_bytes.push_back({fin, rsv, op});
        case (form)
            LEN_EXT16: begin
                wire_bytes.push_back({masked, LEN16_CODE});
                wire_bytes.push_back(flen[15:8]);
                wire_bytes.push_back(flen[7:0]);
            end
            LEN_EXT64: begin
                wire_bytes.push_back({masked, LEN64_CODE});
                for (int i = 7; i >= 0; i--)
                    wire_bytes.push_back(flen[8*i +: 8]);
            end
            default: begin
                wire_bytes.push_back({masked, flen[6:0]});
            end
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                wire_bytes.push_back(key[8*i +: 8]);
        repeat (body_len) wire_bytes.push_back(8'($urandom));
    endtask

    function automatic len_form_t pick_form();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return LEN_EXT16;
        if (roll == 1)
            return LEN_EXT64;
        return LEN_SHORT;
    endfunction

    task automatic add_control_frame();
        int               n;
        logic [OPCODE_W-1:0] op;
        n  = $urandom_range(0, 6);
        op = $urandom_range(0, 1) ? OP_PING : OP_PONG;
        add_frame($urandom_range(0, 9) != 0, 3'b000, op, 1'($urandom), pick_form(),
                  64'(n), n);
    endtask

    task automatic add_data_frame(input logic fin, input logic [OPCODE_W-1:0] op);
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        add_frame(fin, 3'b000, op, 1'($urandom), pick_form(), 64'(n), n);
    endtask

    // First header byte that the parser rejects: reserved bit or bad opcode.
    function automatic logic [7:0] bad_header_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 1)) begin
            if (b[6:4] == 3'b000)
                b[6:4] = 3'($urandom_range(1, 7));
        end else begin
            b[6:4] = 3'b000;
            while (b[3:0] <= OP_BINARY || (b[3:0] >= OP_CLOSE && b[3:0] <= OP_PONG))
                b[3:0] = 4'($urandom);
        end
        return b;
    endfunction

    // Mostly well-formed messages (fragmented, with interleaved control
    // frames), plus rejected headers, oversize frames and stray bytes.
    task automatic add_random_traffic(input int budget);
        int                  roll;
        int                  frags;
        int                  goal;
        logic [OPCODE_W-1:0] op;
        goal = wire_bytes.size() + budget;
        while (wire_bytes.size() < goal) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
                frags = $urandom_range(1, 3);
                case ($urandom_range(0, 15))
                    0:       op = OP_CONT;
                    1, 2:    op = OP_CLOSE;
                    3, 4, 5, 6, 7, 8: op = OP_TEXT;
                    default: op = OP_BINARY;
                endcase
                for (int f = 0; f < frags; f++) begin
                    if (f > 0 && $urandom_range(0, 7) == 0)
                        add_control_frame();
                    add_data_frame(f == frags - 1, (f == 0) ? op : OP_CONT);
                end
            end else if (roll < 84) begin
                add_control_frame();
            end else if (roll < 93) begin
                wire_bytes.push_back(bad_header_byte());
            end else if (roll < 97) begin
                add_frame(1'($urandom), 3'b000, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY,
                          1'($urandom), LEN_EXT64,
                          {32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)}, 0);
            end else begin
                wire_bytes.push_back(8'($urandom));
            end
        end
    endtask

    // Drive every queued byte; the calm stretch covers byte indexes [calm_lo,
    // calm_hi), where valid stays high from one byte to the next; outside it, random gaps drop valid.
    task automatic transmit(input int calm_lo, input int calm_hi);
        int         idx;
        logic [7:0] b;
        idx = 0;
        while (wire_bytes.size() != 0) begin
            b = wire_bytes.pop_front();
            calm <= (idx >= calm_lo && idx < calm_hi);
            if (!(idx >= calm_lo && idx < calm_hi)) begin
                while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                end
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            do @(posedge aclk); while (!s_tready);
            idx++;
        end
    endtask

    // Drop valid, wait for every expected event, then let the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        calm     <= 1'b0;
        do @(posedge aclk); while (events_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [MAX_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames under the reset limit.
        add_frame(1'b1, 3'b000, OP_TEXT, 1'b0, LEN_SHORT, 3, 3);
        // masked frames: key wraps inside the first, restarts on the second
        add_frame(1'b1, 3'b000, OP_BINARY, 1'b1, LEN_SHORT, 5, 5);
        add_frame(1'b1, 3'b000, OP_BINARY, 1'b1, LEN_SHORT, 3, 3);
        // fragmented text with an empty middle fragment; opcode carries over
        add_frame(1'b0, 3'b000, OP_TEXT, 1'b1, LEN_SHORT, 2, 2);
        add_frame(1'b0, 3'b000, OP_CONT, 1'b0, LEN_SHORT, 0, 0);
        add_frame(1'b1, 3'b000, OP_CONT, 1'b1, LEN_EXT16, 2, 2);
        // continuation with no message open
        add_frame(1'b1, 3'b000, OP_CONT, 1'b0, LEN_SHORT, 1, 1);
        // empty final frame gives the message-end event
        add_frame(1'b1, 3'b000, OP_TEXT, 1'b0, LEN_SHORT, 0, 0);
        // control frames: ping with body, empty ping and pong, long-form pong
        add_frame(1'b1, 3'b000, OP_PING, 1'b1, LEN_EXT16, 4, 4);
        add_frame(1'b1, 3'b000, OP_PING, 1'b0, LEN_SHORT, 0, 0);
        add_frame(1'b1, 3'b000, OP_PONG, 1'b0, LEN_SHORT, 0, 0);
        add_frame(1'b1, 3'b000, OP_PONG, 1'b1, LEN_EXT64, 3, 3);
        add_frame(1'b1, 3'b000, OP_CLOSE, 1'b0, LEN_EXT64, 2, 2);
        // body byte extremes
        add_frame(1'b1, 3'b000, OP_BINARY, 1'b0, LEN_SHORT, 2, 0);
        wire_bytes.push_back(8'h00);
        wire_bytes.push_back(8'hFF);
        // all-zero header byte: empty non-final continuation, no event
        add_frame(1'b0, 3'b000, OP_CONT, 1'b0, LEN_SHORT, 0, 0);
        // each reserved bit, and every bit of the first byte set
        wire_bytes.push_back({1'b1, 3'b001, OP_TEXT});
        wire_bytes.push_back({1'b0, 3'b010, OP_BINARY});
        wire_bytes.push_back({1'b1, 3'b100, OP_CONT});
        wire_bytes.push_back(8'hFF);
        // invalid opcodes at both ends of both holes
        wire_bytes.push_back({1'b1, 3'b000, OP_BINARY + 4'd1});
        wire_bytes.push_back({1'b0, 3'b000, OP_CLOSE - 4'd1});
        wire_bytes.push_back({1'b1, 3'b000, OP_PONG + 4'd1});
        wire_bytes.push_back({1'b1, 3'b000, 4'hF});
        // 64-bit length with its top bit set, and a length just over the limit
        add_frame(1'b1, 3'b000, OP_BINARY, 1'b1, LEN_EXT64, 64'h8000_0000_0000_0001, 0);
        add_frame(1'b0, 3'b000, OP_TEXT, 1'b0, LEN_EXT64, 64'(MAX_MESSAGE_RESET), 0);
        transmit(0, 0);
        settle();

        add_random_traffic(RANDOM_BYTES);
        transmit(0, 0);
        settle();

        // Smallest limit: every data frame is oversize, control frames pass.
        write_limit(32'd1);
        add_frame(1'b1, 3'b000, OP_TEXT, 1'b0, LEN_SHORT, 0, 0);
        add_frame(1'b1, 3'b000, OP_PING, 1'b1, LEN_SHORT, 2, 2);
        add_frame(1'b1, 3'b000, OP_PONG, 1'b0, LEN_SHORT, 1, 1);
        add_frame(1'b0, 3'b000, OP_BINARY, 1'b1, LEN_EXT16, 0, 0);
        transmit(0, 0);
        settle();

        // Largest limit: only lengths past 32 bits or the sum can fail.
        write_limit('1);
        add_frame(1'b1, 3'b000, OP_TEXT, 1'b0, LEN_EXT64, 64'h1_0000_0000, 0);
        add_frame(1'b1, 3'b000, OP_BINARY, 1'b1, LEN_EXT64, 64'hFFFF_FFF8, 0);
        add_frame(1'b1, 3'b000, OP_TEXT, 1'b0, LEN_EXT16, 4, 4);
        add_random_traffic(RANDOM_BYTES);
        transmit(0, 0);
        settle();

        // Mid limit: a fragmented message runs over on its second fragment,
        // then a continuation still carries the text opcode.
        mid_limit = $urandom_range(48, 96);
        write_limit(mid_limit);
        add_frame(1'b0, 3'b000, OP_TEXT, 1'b0, LEN_SHORT, 64'(mid_limit / 2), mid_limit / 2);
        add_frame(1'b0, 3'b000, OP_CONT, 1'b1, LEN_SHORT, 64'(mid_limit / 2), 0);
        add_frame(1'b1, 3'b000, OP_CONT, 1'b1, LEN_SHORT, 3, 3);
        add_random_traffic(RANDOM_BYTES);
        transmit(60, 200);
        settle();

        if (mismatch_count == 0 && events_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
